/* rtl/smau_pkg.sv */
// Shared types and constants for the small matrix arithmetic unit.
package smau_pkg;

  localparam int MAX_DIM_DEF   = 4;
  localparam int ELEM_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // Fixed port field widths
  localparam int CMD_BITS  = 2;
  localparam int OP_BITS   = 3;
  localparam int COL_BITS  = 2;
  localparam int PORT_ELEM = 32;
  localparam int DIM_BITS  = 3;
  localparam int LANES     = 4;
  localparam int DATA_BITS = 136;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_LOAD_VEC,
    CMD_EXEC
  } cmd_t;

  typedef enum logic [OP_BITS-1:0] {
    OP_TRANSPOSE,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_VEC_MAT,
    OP_MAT_VEC
  } op_t;

  // Step controls from the sequencer to the shared arithmetic unit
  typedef struct packed {
    logic load;   // capture operands
    logic mul;    // form product and simple sum
    logic acc;    // add product into accumulator
    logic clear;  // start a fresh dot product
    op_t  op;
  } mac_ctl_t;

endpackage

/* rtl/small_matrix_arithmetic_unit.sv */
// Top level: matrix/vector storage, element sequencer and result register.
//
//  channel   | signals                          | carries
//  ----------+----------------------------------+---------------------------------------
//  input     | s_tvalid s_tready s_tdata        | load A/B column, load vector, execute
//  result    | m_tvalid m_tready m_tdata m_tlast| one result column, last column marked
//  config    | cfg_valid cfg_ready cfg_data     | dim register, always ready
//
//  Loads write storage straight from the input word. An execute walks one shared
//  multiply-accumulate unit over the result elements: a dot product steps through
//  fetch, multiply and accumulate for each term, then finish; a transpose, add or
//  subtract element steps through fetch, multiply and finish. Each finished column
//  then passes through a hand-off step into the output register. Reset (rst,
//  synchronous) clears A, B, the vector and sets dim to 4. The input stays not
//  ready while an execute runs; a full output register stalls the sequencer, and
//  a finished last column does not block the next request.
module small_matrix_arithmetic_unit #(
  parameter int MAX_DIM   = smau_pkg::MAX_DIM_DEF,
  parameter int ELEM_BITS = smau_pkg::ELEM_BITS_DEF,
  parameter int FRAC_BITS = smau_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // cmd[1:0], op[4:2], col[6:5], e0[38:7], e1[70:39], e2[102:71], e3[134:103]
  input  logic [smau_pkg::DATA_BITS-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // res_col[1:0], res_e0[33:2], res_e1[65:34], res_e2[97:66], res_e3[129:98]
  output logic [smau_pkg::DATA_BITS-1:0]     m_tdata,
  output logic                               m_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [smau_pkg::DIM_BITS-1:0]      cfg_data
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int LW = smau_pkg::PORT_ELEM;
  localparam int E_LSB = smau_pkg::CMD_BITS + smau_pkg::OP_BITS + smau_pkg::COL_BITS;

  typedef enum logic [2:0] {
    IDLE,
    FETCH,
    MUL,
    ACC,
    FIN,
    EMIT
  } state_t;

  state_t                         state;
  logic [smau_pkg::DIM_BITS-1:0]  dim;
  logic [CW-1:0]                  dlast;
  logic [CW-1:0]                  dlast_cfg;
  logic [CW-1:0]                  c;
  logic [CW-1:0]                  r;
  logic [CW-1:0]                  k;
  smau_pkg::op_t                  op_q;

  logic signed [ELEM_BITS-1:0] a_mem  [MAX_DIM][MAX_DIM];
  logic signed [ELEM_BITS-1:0] b_mem  [MAX_DIM][MAX_DIM];
  logic signed [ELEM_BITS-1:0] vec    [MAX_DIM];
  logic signed [ELEM_BITS-1:0] colbuf [MAX_DIM];
  logic signed [ELEM_BITS-1:0] e_in   [MAX_DIM];

  smau_pkg::cmd_t                 s_cmd;
  logic [smau_pkg::OP_BITS-1:0]   s_op;
  logic [smau_pkg::COL_BITS-1:0]  s_col;
  logic                           s_fire;
  logic                           out_free;
  logic                           is_mac;
  logic                           vec_out;

  logic [CW-1:0]                  a_col;
  logic [CW-1:0]                  a_row;
  logic signed [ELEM_BITS-1:0]    opx_sel;
  logic signed [ELEM_BITS-1:0]    opy_sel;
  logic signed [ELEM_BITS-1:0]    mac_res;
  smau_pkg::mac_ctl_t             mac_ctl;
  logic [smau_pkg::DATA_BITS-1:0] out_word;

  assign s_tready  = (state == IDLE);
  assign cfg_ready = 1'b1;
  assign s_fire    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign s_cmd = smau_pkg::cmd_t'(s_tdata[1:0]);
  assign s_op  = s_tdata[4:2];
  assign s_col = s_tdata[6:5];

  // Keep the low element bits of each input lane
  always_comb begin
    for (int i = 0; i < MAX_DIM; i++) begin
      e_in[i] = s_tdata[E_LSB + LW*i +: ELEM_BITS];
    end
  end

  // Clamp dim into 2..MAX_DIM and hold it as the last valid index
  always_comb begin
    if (dim < 3'd2) begin
      dlast_cfg = CW'(1);
    end else if (dim > smau_pkg::DIM_BITS'(MAX_DIM)) begin
      dlast_cfg = CW'(MAX_DIM - 1);
    end else begin
      dlast_cfg = CW'(dim - 3'd1);
    end
  end

  assign is_mac  = (op_q == smau_pkg::OP_MUL) || (op_q == smau_pkg::OP_VEC_MAT) ||
                   (op_q == smau_pkg::OP_MAT_VEC);
  assign vec_out = (op_q == smau_pkg::OP_VEC_MAT) || (op_q == smau_pkg::OP_MAT_VEC);

  // Operand routing: pick the A element and the B or vector element of this step
  always_comb begin
    case (op_q)
      smau_pkg::OP_TRANSPOSE: begin
        a_col = r;
        a_row = c;
      end
      smau_pkg::OP_ADD, smau_pkg::OP_SUB: begin
        a_col = c;
        a_row = r;
      end
      smau_pkg::OP_VEC_MAT: begin
        a_col = r;
        a_row = k;
      end
      default: begin
        a_col = k;
        a_row = r;
      end
    endcase
    opx_sel = a_mem[a_col][a_row];
    case (op_q)
      smau_pkg::OP_MUL:                           opy_sel = b_mem[c][k];
      smau_pkg::OP_ADD, smau_pkg::OP_SUB:         opy_sel = b_mem[c][r];
      smau_pkg::OP_VEC_MAT, smau_pkg::OP_MAT_VEC: opy_sel = vec[k];
      default:                                    opy_sel = '0;
    endcase
  end

  always_comb begin
    mac_ctl.load  = (state == FETCH);
    mac_ctl.mul   = (state == MUL);
    mac_ctl.acc   = (state == ACC);
    mac_ctl.clear = (k == '0);
    mac_ctl.op    = op_q;
  end

  smau_mac #(
    .ELEM_BITS (ELEM_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .opx_in (opx_sel),
    .opy_in (opy_sel),
    .result (mac_res)
  );

  // Pack the finished column; lanes beyond MAX_DIM read as zero
  always_comb begin
    out_word = '0;
    out_word[smau_pkg::COL_BITS-1:0] = vec_out ? smau_pkg::COL_BITS'(0)
                                               : smau_pkg::COL_BITS'(c);
    for (int i = 0; i < MAX_DIM; i++) begin
      out_word[smau_pkg::COL_BITS + LW*i +: LW] = LW'(colbuf[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      dim      <= smau_pkg::DIM_BITS'(smau_pkg::MAX_DIM_DEF);
      dlast    <= '0;
      c        <= '0;
      r        <= '0;
      k        <= '0;
      op_q     <= smau_pkg::OP_TRANSPOSE;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
      for (int i = 0; i < MAX_DIM; i++) begin
        vec[i] <= '0;
        for (int j = 0; j < MAX_DIM; j++) begin
          a_mem[i][j] <= '0;
          b_mem[i][j] <= '0;
        end
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        dim <= cfg_data;
      end
      // Drop the output once the downstream side takes it; the hand-off step
      // refills it on its own
      if (m_tvalid && m_tready && (state != EMIT)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (s_fire) begin
            case (s_cmd)
              smau_pkg::CMD_LOAD_A: begin
                if (smau_pkg::DIM_BITS'(s_col) < smau_pkg::DIM_BITS'(MAX_DIM)) begin
                  for (int i = 0; i < MAX_DIM; i++) begin
                    a_mem[s_col[CW-1:0]][i] <= e_in[i];
                  end
                end
              end
              smau_pkg::CMD_LOAD_B: begin
                if (smau_pkg::DIM_BITS'(s_col) < smau_pkg::DIM_BITS'(MAX_DIM)) begin
                  for (int i = 0; i < MAX_DIM; i++) begin
                    b_mem[s_col[CW-1:0]][i] <= e_in[i];
                  end
                end
              end
              smau_pkg::CMD_LOAD_VEC: begin
                for (int i = 0; i < MAX_DIM; i++) begin
                  vec[i] <= e_in[i];
                end
              end
              default: begin
                // Execute: unknown ops are swallowed with no result
                if (s_op inside {[smau_pkg::OP_TRANSPOSE:smau_pkg::OP_MAT_VEC]}) begin
                  op_q  <= smau_pkg::op_t'(s_op);
                  dlast <= dlast_cfg;
                  c     <= '0;
                  r     <= '0;
                  k     <= '0;
                  for (int i = 0; i < MAX_DIM; i++) begin
                    colbuf[i] <= '0;
                  end
                  state <= FETCH;
                end
              end
            endcase
          end
        end
        FETCH: begin
          state <= MUL;
        end
        MUL: begin
          state <= is_mac ? ACC : FIN;
        end
        ACC: begin
          if (k == dlast) begin
            state <= FIN;
          end else begin
            k     <= k + 1'b1;
            state <= FETCH;
          end
        end
        FIN: begin
          colbuf[r] <= mac_res;
          k         <= '0;
          if (r == dlast) begin
            state <= EMIT;
          end else begin
            r     <= r + 1'b1;
            state <= FETCH;
          end
        end
        EMIT: begin
          // Hold the column until the output register is free
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= out_word;
            m_tlast  <= vec_out || (c == dlast);
            if (vec_out || (c == dlast)) begin
              state <= IDLE;
            end else begin
              c     <= c + 1'b1;
              r     <= '0;
              state <= FETCH;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // A new result only appears from the column hand-off step
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == EMIT))
    else $error("result raised outside column hand-off");

  // Loads and unknown executes finish in the cycle they are accepted
  a_quick_cmd: assert property (@(posedge clk) disable iff (rst)
    (s_fire && (s_cmd != smau_pkg::CMD_EXEC || s_op > smau_pkg::OP_MAT_VEC))
      |=> s_tready)
    else $error("single-cycle request did not return to ready");

  // Sequencer indexes never pass the active dimension
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state != IDLE) |-> (k <= dlast && r <= dlast && c <= dlast))
    else $error("sequencer index beyond active dimension");

  // The last column of a run is marked exactly when the sequencer goes idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    ($past(state == EMIT) && $rose(m_tvalid) && m_tlast) |-> (state == IDLE))
    else $error("last result without return to idle");

endmodule

/* rtl/smau_mac.sv */
// Shared multiply-accumulate and saturating add/subtract unit for the matrix sequencer.
module smau_mac #(
  parameter int ELEM_BITS = smau_pkg::ELEM_BITS_DEF,
  parameter int FRAC_BITS = smau_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  smau_pkg::mac_ctl_t          ctl,
  input  logic signed [ELEM_BITS-1:0] opx_in,
  input  logic signed [ELEM_BITS-1:0] opy_in,
  output logic signed [ELEM_BITS-1:0] result
);

  localparam int PROD_BITS = 2 * ELEM_BITS;
  localparam int ACC_BITS  = PROD_BITS + 2;
  localparam int SUM_BITS  = ELEM_BITS + 1;

  localparam logic signed [ACC_BITS-1:0] ACC_MAX =
    {{(ACC_BITS-ELEM_BITS+1){1'b0}}, {(ELEM_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = ~ACC_MAX;
  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {2'b00, {(ELEM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = ~SUM_MAX;
  localparam logic signed [ELEM_BITS-1:0] E_MAX = {1'b0, {(ELEM_BITS-1){1'b1}}};
  localparam logic signed [ELEM_BITS-1:0] E_MIN = ~E_MAX;

  logic signed [ELEM_BITS-1:0] opx;
  logic signed [ELEM_BITS-1:0] opy;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [SUM_BITS-1:0]  sres;
  logic signed [SUM_BITS-1:0]  sres_next;
  logic signed [ACC_BITS-1:0]  acc;
  logic signed [ACC_BITS-1:0]  acc_sh;
  logic                        is_mac;

  always_comb begin
    case (ctl.op)
      smau_pkg::OP_TRANSPOSE: sres_next = SUM_BITS'(opx);
      smau_pkg::OP_ADD:       sres_next = SUM_BITS'(opx) + SUM_BITS'(opy);
      smau_pkg::OP_SUB:       sres_next = SUM_BITS'(opx) - SUM_BITS'(opy);
      default:                sres_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      opx <= opx_in;
      opy <= opy_in;
    end
    if (ctl.mul) begin
      prod <= opx * opy;
      sres <= sres_next;
    end
    if (ctl.acc) begin
      acc <= (ctl.clear ? ACC_BITS'(0) : acc) + ACC_BITS'(prod);
    end
  end

  // Floor shift back to element scale, then clamp to the element range
  assign acc_sh = acc >>> FRAC_BITS;
  assign is_mac = (ctl.op == smau_pkg::OP_MUL) || (ctl.op == smau_pkg::OP_VEC_MAT) ||
                  (ctl.op == smau_pkg::OP_MAT_VEC);

  always_comb begin
    if (is_mac) begin
      if (acc_sh > ACC_MAX) begin
        result = E_MAX;
      end else if (acc_sh < ACC_MIN) begin
        result = E_MIN;
      end else begin
        result = acc_sh[ELEM_BITS-1:0];
      end
    end else begin
      if (sres > SUM_MAX) begin
        result = E_MAX;
      end else if (sres < SUM_MIN) begin
        result = E_MIN;
      end else begin
        result = sres[ELEM_BITS-1:0];
      end
    end
  end

endmodule
